// File: design/positional_list_editor_core_assert.svh
`ifndef POSITIONAL_LIST_EDITOR_CORE_ASSERT_SVH
`define POSITIONAL_LIST_EDITOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLE_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// File: design/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY_DEF = 16;

    // Wide enough for any list index or count in the supported capacity range.
    localparam int IDX_W = 7;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_POS   = 3'd5;
    localparam logic [2:0] CMD_DUMP      = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t CELL_HOLD = 2'd0;
    localparam cell_op_t CELL_INS  = 2'd1;
    localparam cell_op_t CELL_DEL  = 2'd2;
    localparam cell_op_t CELL_ROT  = 2'd3;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last;
    } ple_ctl_t;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [7:0]         position;
        logic signed [31:0] value;
    } ple_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         length;
        logic signed [31:0] entry;
        logic               final_res;
    } ple_rsp_t;

endpackage

// File: design/ple_cell.sv
module ple_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  ple_pkg::ple_ctl_t   ctl,
    input  logic signed [31:0]  value,
    input  logic signed [31:0]  left_in,
    input  logic signed [31:0]  right_in,
    input  logic signed [31:0]  first_in,
    output logic signed [31:0]  entry
);

    localparam logic [ple_pkg::IDX_W-1:0] MY_IDX = ple_pkg::IDX_W'(INDEX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctl.op)
            ple_pkg::CELL_INS:
            begin
                if (MY_IDX == ctl.idx)
                begin
                    entry_next = value;
                end
                else if (MY_IDX > ctl.idx)
                begin
                    entry_next = left_in;
                end
            end
            ple_pkg::CELL_DEL:
            begin
                if (MY_IDX >= ctl.idx)
                begin
                    entry_next = right_in;
                end
            end
            ple_pkg::CELL_ROT:
            begin
                // The occupied part of the row turns by one toward cell 0.
                if (MY_IDX < ctl.last)
                begin
                    entry_next = right_in;
                end
                else if (MY_IDX == ctl.last)
                begin
                    entry_next = first_in;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: design/positional_list_editor_core.sv
// Channel   | Handshake               | Payload
// ----------+-------------------------+-----------------------------
// request   | start, busy (in = !busy)| req   (cmd, position, value)
// result    | result_valid (1 cycle)  | result (status, length, entry, final_res)
//
// Every edit is taken when start is high and busy is low; its result is registered
// and appears in the next cycle; edits may follow each other in consecutive cycles.
// A dump of n entries gives n results in consecutive cycles, one entry per cycle
// as the cell row turns past cell 0; busy is high while later entries go out. An empty
// dump gives one result. Reset clears count, state, result_valid; entries stay unknown.
// Results cannot be stalled: each is valid for exactly one cycle.
module positional_list_editor_core #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ple_pkg::ple_req_t req,
    output logic              result_valid,
    output ple_pkg::ple_rsp_t result
);

    localparam int FILL_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W-1:0]    dump_cnt_reg;
    logic [FILL_W-1:0]    dump_cnt_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    ple_pkg::ple_rsp_t    result_reg;
    ple_pkg::ple_rsp_t    result_next;
    ple_pkg::ple_ctl_t    ctl;
    logic                 accept;
    logic [1:0]           st;
    logic [8:0]           pos9;
    logic [8:0]           fill9;
    logic                 full;

    logic signed [31:0]   cell_q     [CAPACITY];
    logic signed [31:0]   left_w     [CAPACITY];
    logic signed [31:0]   right_w    [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cells
        if (g == 0)
        begin : g_first
            assign left_w[g] = '0;
        end
        else
        begin : g_mid_l
            assign left_w[g] = cell_q[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_w[g] = '0;
        end
        else
        begin : g_mid_r
            assign right_w[g] = cell_q[g+1];
        end

        ple_cell #(
            .INDEX(g)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .value    (req.value),
            .left_in  (left_w[g]),
            .right_in (right_w[g]),
            .first_in (cell_q[0]),
            .entry    (cell_q[g])
        );
    end

    assign busy   = (state_reg == S_DUMP);
    assign accept = start && !busy;
    assign pos9   = 9'(req.position);
    assign fill9  = 9'(fill_reg);
    assign full   = (fill_reg >= FILL_W'(CAPACITY));

    always_comb
    begin
        state_next        = state_reg;
        fill_next         = fill_reg;
        dump_cnt_next     = dump_cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        ctl.op            = ple_pkg::CELL_HOLD;
        ctl.idx           = '0;
        ctl.last          = ple_pkg::IDX_W'(fill_reg - 1'b1);
        st                = ple_pkg::ST_OK;

        if (state_reg == S_DUMP)
        begin
            ctl.op                = ple_pkg::CELL_ROT;
            result_valid_next     = 1'b1;
            result_next.status    = ple_pkg::ST_OK;
            result_next.length    = 7'(fill_reg);
            result_next.entry     = cell_q[0];
            result_next.final_res = (dump_cnt_reg == FILL_W'(1));
            dump_cnt_next         = dump_cnt_reg - 1'b1;
            if (dump_cnt_reg == FILL_W'(1))
            begin
                state_next = S_IDLE;
            end
        end
        else if (accept)
        begin
            result_valid_next = 1'b1;
            unique case (req.cmd) inside
                ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_BACK:
                begin
                    if (full)
                    begin
                        st = ple_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.op    = ple_pkg::CELL_INS;
                        ctl.idx   = (req.cmd == ple_pkg::CMD_INS_FRONT) ?
                                    '0 : ple_pkg::IDX_W'(fill_reg);
                        fill_next = fill_reg + 1'b1;
                    end
                end
                ple_pkg::CMD_INS_POS:
                begin
                    if (pos9 == 9'd0 || pos9 > fill9 + 9'd1)
                    begin
                        st = ple_pkg::ST_BADPOS;
                    end
                    else if (full)
                    begin
                        st = ple_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.op    = ple_pkg::CELL_INS;
                        ctl.idx   = ple_pkg::IDX_W'(pos9 - 9'd1);
                        fill_next = fill_reg + 1'b1;
                    end
                end
                ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK:
                begin
                    if (fill_reg == '0)
                    begin
                        st = ple_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.op    = ple_pkg::CELL_DEL;
                        ctl.idx   = (req.cmd == ple_pkg::CMD_DEL_FRONT) ?
                                    '0 : ple_pkg::IDX_W'(fill_reg - 1'b1);
                        fill_next = fill_reg - 1'b1;
                    end
                end
                ple_pkg::CMD_DEL_POS:
                begin
                    if (pos9 == 9'd0 || pos9 > fill9)
                    begin
                        st = ple_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        ctl.op    = ple_pkg::CELL_DEL;
                        ctl.idx   = ple_pkg::IDX_W'(pos9 - 9'd1);
                        fill_next = fill_reg - 1'b1;
                    end
                end
                ple_pkg::CMD_DUMP:
                begin
                    if (fill_reg == '0)
                    begin
                        st = ple_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // The first entry goes out now; the rest follow as the row turns.
                        ctl.op        = ple_pkg::CELL_ROT;
                        dump_cnt_next = fill_reg - 1'b1;
                        if (fill_reg != FILL_W'(1))
                        begin
                            state_next = S_DUMP;
                        end
                    end
                end
                default:
                begin
                    result_valid_next = 1'b0;
                end
            endcase

            result_next.status    = st;
            result_next.length    = 7'(fill_next);
            result_next.entry     = '0;
            result_next.final_res = 1'b1;
            if (req.cmd == ple_pkg::CMD_DUMP && fill_reg != '0)
            begin
                result_next.entry     = cell_q[0];
                result_next.final_res = (fill_reg == FILL_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            fill_reg         <= '0;
            dump_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fill_reg         <= fill_next;
            dump_cnt_reg     <= dump_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`include "positional_list_editor_core_assert.svh"

    `PLE_ASSERT_SAME(a_fill_cap, clk, rst_n, 1'b1, fill_reg <= FILL_W'(CAPACITY), "count above capacity")
    `PLE_ASSERT_NEXT(a_dump_emits, clk, rst_n, busy, result_valid, "dump cycle without result")
    `PLE_ASSERT_NEXT(a_dump_ends, clk, rst_n, busy && dump_cnt_reg == FILL_W'(1), !busy, "dump did not end")
    `PLE_ASSERT_NEXT(a_fill_stable, clk, rst_n, !accept, $stable(fill_reg), "count changed without request")

endmodule
